@@ rtl/lzwd_pkg.sv @@
// lzwd_pkg: shared types and constants of the lz10 window decompressor
`default_nettype none

package lzwd_pkg;

   // controller states
   typedef enum logic [1:0] {
      CS_IDLE,
      CS_READ,
      CS_EMIT
   } ctrl_state_type;

   // parser phases
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_REF2,
      PH_DONE
   } phase_type;

   // result status codes
   localparam logic [1:0] ST_DATA       = 2'd0;
   localparam logic [1:0] ST_BAD_HEADER = 2'd1;
   localparam logic [1:0] ST_BAD_REF    = 2'd2;

   localparam logic [7:0] HDR_TYPE     = 8'h10;
   localparam logic [3:0] GROUP_TOKENS = 4'd8;
   localparam logic [4:0] LEN_BIAS     = 5'd3;
   localparam int         SIZE_W       = 24;
   localparam int         DIST_W       = 12;
   localparam int         CNT_W        = 5;

   typedef struct packed {
      logic accept;
      logic read;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic copy_start;
      logic copy_last;
   } dp_sts_type;

endpackage

`default_nettype wire

@@ rtl/lzwd_ctrl.sv @@
// lzwd_ctrl: sequencer for input acceptance and back-reference copies
`default_nettype none

module lzwd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lzwd_pkg::dp_sts_type  sts,
   output lzwd_pkg::dp_cmd_type       cmd
);

   lzwd_pkg::ctrl_state_type state_ff;
   lzwd_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwd_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lzwd_pkg::CS_IDLE: begin
            req_ready  = sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept && sts.copy_start) begin
               state_in = lzwd_pkg::CS_READ;
            end
         end
         lzwd_pkg::CS_READ: begin
            cmd.read = 1'b1;
            state_in = lzwd_pkg::CS_EMIT;
         end
         lzwd_pkg::CS_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.copy_last) begin
                  state_in = lzwd_pkg::CS_IDLE;
               end else begin
                  state_in = lzwd_pkg::CS_READ;
               end
            end
         end
         default: begin
            state_in = lzwd_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/lzwd_datapath.sv @@
// lzwd_datapath: stream parser, history window and result register
`default_nettype none

module lzwd_datapath #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  req_stream_start,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_end_of_data,
   input  wire lzwd_pkg::dp_cmd_type  cmd,
   output lzwd_pkg::dp_sts_type       sts
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int SW = lzwd_pkg::SIZE_W;
   localparam int DW = lzwd_pkg::DIST_W;
   localparam int CW = lzwd_pkg::CNT_W;

   lzwd_pkg::phase_type phase_ff, phase_in, e_phase;
   logic [1:0]    hidx_ff, hidx_in, e_hidx;
   logic [AW-1:0] wp_ff, wp_in, e_wp;
   logic [SW-1:0] prod_ff, prod_in, e_prod;
   logic [SW-1:0] decl_ff, decl_in, e_decl, hdr_decl;
   logic [3:0]    tokpos_ff, tokpos_in, e_tokpos;
   logic [7:0]    flags_ff, flags_in, e_flags;
   logic [7:0]    pending_ff, pending_in, e_pending;
   logic          halted_ff, halted_in, e_halted;
   logic [DW-1:0] dist_ff, dist_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    rd_data_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_eod_ff, rsp_eod_in;

   logic [7:0]    win_mem [WINDOW_DEPTH];
   logic [AW-1:0] src_addr;
   logic          wr_en;
   logic [7:0]    wr_data;
   logic          out_free;
   logic          out_load;
   logic          fin;

   logic [DW:0]   ref_dist;
   logic          ref_bad;
   logic [SW-1:0] owed;
   logic [CW-1:0] ref_len, clip_len;

   // state as seen after an optional restart
   assign e_phase   = req_stream_start ? lzwd_pkg::PH_HEADER : phase_ff;
   assign e_hidx    = req_stream_start ? 2'd0 : hidx_ff;
   assign e_wp      = req_stream_start ? '0 : wp_ff;
   assign e_prod    = req_stream_start ? '0 : prod_ff;
   assign e_decl    = req_stream_start ? '0 : decl_ff;
   assign e_tokpos  = req_stream_start ? lzwd_pkg::GROUP_TOKENS : tokpos_ff;
   assign e_flags   = req_stream_start ? 8'd0 : flags_ff;
   assign e_pending = req_stream_start ? 8'd0 : pending_ff;
   assign e_halted  = req_stream_start ? 1'b0 : halted_ff;

   // second reference byte
   assign ref_dist = {1'b0, pending_ff[3:0], req_in_byte} + (DW+1)'(1);
   assign ref_bad  = {(SW-DW-1)'(0), ref_dist} > prod_ff;
   assign owed     = decl_ff - prod_ff;
   assign ref_len  = {1'b0, pending_ff[7:4]} + lzwd_pkg::LEN_BIAS;
   assign clip_len = (owed < {(SW-CW)'(0), ref_len}) ? owed[CW-1:0] : ref_len;

   assign sts.copy_start = !req_stream_start && !halted_ff
                           && (phase_ff == lzwd_pkg::PH_REF2) && !ref_bad;
   assign sts.copy_last  = (cnt_ff == CW'(1));
   assign sts.out_free   = out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign src_addr = wp_ff - AW'(dist_ff) - AW'(1);
   assign fin      = ((prod_ff + SW'(1)) == decl_ff);

   always_comb begin
      hdr_decl = e_decl;
      case (e_hidx)
         2'd1:    hdr_decl[7:0]   = e_decl[7:0]   | req_in_byte;
         2'd2:    hdr_decl[15:8]  = e_decl[15:8]  | req_in_byte;
         2'd3:    hdr_decl[23:16] = e_decl[23:16] | req_in_byte;
         default: hdr_decl = e_decl;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      hidx_in       = hidx_ff;
      wp_in         = wp_ff;
      prod_in       = prod_ff;
      decl_in       = decl_ff;
      tokpos_in     = tokpos_ff;
      flags_in      = flags_ff;
      pending_in    = pending_ff;
      halted_in     = halted_ff;
      dist_in       = dist_ff;
      cnt_in        = cnt_ff;
      wr_en         = 1'b0;
      wr_data       = 8'd0;
      out_load      = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_eod_in    = rsp_eod_ff;

      if (cmd.accept) begin
         phase_in   = e_phase;
         hidx_in    = e_hidx;
         wp_in      = e_wp;
         prod_in    = e_prod;
         decl_in    = e_decl;
         tokpos_in  = e_tokpos;
         flags_in   = e_flags;
         pending_in = e_pending;
         halted_in  = e_halted;
         if (!e_halted) begin
            case (e_phase)
               lzwd_pkg::PH_HEADER: begin
                  if (e_hidx == 2'd0) begin
                     if (req_in_byte != lzwd_pkg::HDR_TYPE) begin
                        out_load      = 1'b1;
                        rsp_byte_in   = 8'd0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = lzwd_pkg::ST_BAD_HEADER;
                        rsp_eod_in    = 1'b0;
                        halted_in     = 1'b1;
                     end else begin
                        hidx_in = 2'd1;
                     end
                  end else begin
                     decl_in = hdr_decl;
                     hidx_in = e_hidx + 2'd1;
                     if (e_hidx == 2'd3) begin
                        tokpos_in = lzwd_pkg::GROUP_TOKENS;
                        prod_in   = '0;
                        phase_in  = (hdr_decl == '0) ? lzwd_pkg::PH_DONE
                                                     : lzwd_pkg::PH_TOKEN;
                     end
                  end
               end
               lzwd_pkg::PH_TOKEN: begin
                  if (e_tokpos[3]) begin
                     flags_in  = req_in_byte;
                     tokpos_in = 4'd0;
                  end else if (e_flags[3'd7 - e_tokpos[2:0]]) begin
                     pending_in = req_in_byte;
                     phase_in   = lzwd_pkg::PH_REF2;
                  end else begin
                     // literal
                     tokpos_in     = e_tokpos + 4'd1;
                     wr_en         = 1'b1;
                     wr_data       = req_in_byte;
                     wp_in         = wp_ff + AW'(1);
                     prod_in       = prod_ff + SW'(1);
                     out_load      = 1'b1;
                     rsp_byte_in   = req_in_byte;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = lzwd_pkg::ST_DATA;
                     rsp_eod_in    = fin;
                     if (fin) begin
                        phase_in = lzwd_pkg::PH_DONE;
                     end
                  end
               end
               lzwd_pkg::PH_REF2: begin
                  phase_in  = lzwd_pkg::PH_TOKEN;
                  tokpos_in = e_tokpos + 4'd1;
                  if (ref_bad) begin
                     out_load      = 1'b1;
                     rsp_byte_in   = 8'd0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = lzwd_pkg::ST_BAD_REF;
                     rsp_eod_in    = 1'b0;
                     halted_in     = 1'b1;
                  end else begin
                     dist_in = {pending_ff[3:0], req_in_byte};
                     cnt_in  = clip_len;
                  end
               end
               default: begin
                  phase_in = e_phase;
               end
            endcase
         end
      end

      // one copied byte from the window
      if (cmd.emit) begin
         wr_en         = 1'b1;
         wr_data       = rd_data_ff;
         wp_in         = wp_ff + AW'(1);
         prod_in       = prod_ff + SW'(1);
         cnt_in        = cnt_ff - CW'(1);
         out_load      = 1'b1;
         rsp_byte_in   = rd_data_ff;
         rsp_last_in   = (cnt_ff == CW'(1));
         rsp_status_in = lzwd_pkg::ST_DATA;
         rsp_eod_in    = fin;
         if (fin) begin
            phase_in = lzwd_pkg::PH_DONE;
         end
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lzwd_pkg::PH_HEADER;
         hidx_ff      <= 2'd0;
         wp_ff        <= '0;
         prod_ff      <= '0;
         decl_ff      <= '0;
         tokpos_ff    <= lzwd_pkg::GROUP_TOKENS;
         flags_ff     <= 8'd0;
         pending_ff   <= 8'd0;
         halted_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         wp_ff        <= wp_in;
         prod_ff      <= prod_in;
         decl_ff      <= decl_in;
         tokpos_ff    <= tokpos_in;
         flags_ff     <= flags_in;
         pending_ff   <= pending_in;
         halted_ff    <= halted_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff       <= dist_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eod_ff    <= rsp_eod_in;
   end

   // history window
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= win_mem[src_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_end_of_data = rsp_eod_ff;

endmodule

`default_nettype wire

@@ rtl/lz77_window_decompressor.sv @@
// lz77_window_decompressor: top level of the lz10 stream decompressor
`default_nettype none

//  channel   direction  ports                                   beat
//  req       in         req_valid/ready, req_in_byte,           one compressed byte
//                       req_stream_start
//  rsp       out        rsp_valid/ready, rsp_out_byte,          one output byte or
//                       rsp_last_of_run, rsp_status,            an error code
//                       rsp_end_of_data
//
//  a back-reference: its second byte is accepted, then each copied byte takes a
//  window read, then a write and emit; a copy is 1 to 18 bytes
//  reset is synchronous; the window memory is not cleared, the parser returns
//  to expecting a header
//  rsp_ready low with a result pending holds the result register, and with it input and copy output

module lz77_window_decompressor #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_stream_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic [1:0]       rsp_status,
   output logic             rsp_end_of_data
);

   // command and status between sequencer and datapath
   lzwd_pkg::dp_cmd_type cmd;
   lzwd_pkg::dp_sts_type sts;

   // sequencer: idle accepts bytes, read/emit loop runs a copy
   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // parser state, history window and result register
   lzwd_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_status       (rsp_status),
      .rsp_end_of_data  (rsp_end_of_data),
      .cmd              (cmd),
      .sts              (sts)
   );

   // no new byte is taken while a copy is running
   a_no_accept_in_copy : assert property (@(posedge clock) disable iff (reset)
      (cmd.read || cmd.emit) |-> !req_ready)
      else $error("input accepted during a back-reference copy");

   // an accepted back-reference starts with a window read
   a_copy_starts_read : assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.copy_start) |=> cmd.read)
      else $error("back-reference did not start a window read");

   // the byte that completes the stream closes its run
   a_eod_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_data) |-> rsp_last_of_run)
      else $error("end of data not on the last byte of a run");

   // error beats carry a zero byte and close the run
   a_error_beat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != lzwd_pkg::ST_DATA))
         |-> (rsp_out_byte == 8'd0) && rsp_last_of_run && !rsp_end_of_data)
      else $error("malformed error beat");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for the lz10 window decompressor, directed and random streams
`timescale 1ns / 1ps

module tb_top;

   localparam int LIMIT_CYCLES = 400_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int WIN = 4096;

   // ways a random stream can be spoilt
   typedef enum int {
      FAULT_NONE,
      FAULT_TYPE,
      FAULT_REF,
      FAULT_CUT
   } fault_type;

   // one result beat as the block should present it
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
      logic       eod;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_stream_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic [1:0] rsp_status;
   logic       rsp_end_of_data;

   lz77_window_decompressor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_status       (rsp_status),
      .rsp_end_of_data  (rsp_end_of_data)
   );

   always #2 clock = ~clock;

   // bench bookkeeping
   out_beat_type decoded_q[$];   // decompressed beats still owed by the block
   int  errors = 0;
   int  cycles = 0;
   int  bytes_sent = 0;
   int  streams_opened = 0;
   int  data_beats = 0;
   int  fault_beats = 0;
   int  widest_span = 0;
   int  longest_stream = 0;
   bit  calm = 1'b0;             // when set neither side idles

   // shadow of the decoder state
   logic [7:0]  hist_win [0:WIN-1];
   logic [11:0] wr_ptr;
   logic [23:0] out_count;
   logic [23:0] size_decl;
   logic [2:0]  hdr_pos;
   logic [7:0]  flag_bits;
   logic [3:0]  tok_pos;
   logic [7:0]  ref_hi;
   lzwd_pkg::phase_type phase;
   logic        halted;

   // ---------------------------------------------------------------------------
   // decoder shadow
   // ---------------------------------------------------------------------------

   // back to expecting a header, window contents kept
   function automatic void restart_parser();
      wr_ptr    = '0;
      out_count = '0;
      size_decl = '0;
      hdr_pos   = '0;
      flag_bits = '0;
      tok_pos   = lzwd_pkg::GROUP_TOKENS;
      ref_hi    = '0;
      phase     = lzwd_pkg::PH_HEADER;
      halted    = 1'b0;
   endfunction

   // appends one beat to the owed list
   function automatic void owe_beat(input out_beat_type ob);
      decoded_q.insert(decoded_q.size(), ob);
   endfunction

   // one output byte into the window and the queue; high when the size is met
   function automatic bit emit_out(input logic [7:0] v);
      bit fin;
      hist_win[wr_ptr] = v;
      wr_ptr    = wr_ptr + 12'd1;
      out_count = out_count + 24'd1;
      fin = (out_count == size_decl);
      owe_beat('{data: v, last: 1'b0, status: lzwd_pkg::ST_DATA, eod: fin});
      if (fin)
         phase = lzwd_pkg::PH_DONE;
      return fin;
   endfunction

   // works out every beat that one accepted compressed byte causes
   function automatic void decode_byte(input logic [7:0] b, input logic start);
      int           base;
      int           i;
      bit           fin;
      logic [12:0]  span;
      logic [4:0]   len;
      logic [23:0]  owed;
      logic [11:0]  src;
      out_beat_type tail;
      base = decoded_q.size();
      fin  = 1'b0;
      if (start)
         restart_parser();
      if (!halted && phase != lzwd_pkg::PH_DONE) begin
         case (phase)
            lzwd_pkg::PH_HEADER: begin
               if (hdr_pos == 3'd0) begin
                  if (b != lzwd_pkg::HDR_TYPE) begin
                     owe_beat('{data: 8'h00, last: 1'b0,
                                status: lzwd_pkg::ST_BAD_HEADER, eod: 1'b0});
                     halted = 1'b1;
                  end else begin
                     hdr_pos = 3'd1;
                  end
               end else begin
                  // size arrives low byte first
                  size_decl = size_decl | (24'(b) << (8 * (hdr_pos - 3'd1)));
                  hdr_pos = hdr_pos + 3'd1;
                  if (hdr_pos >= 3'd4) begin
                     hdr_pos   = 3'd0;
                     tok_pos   = lzwd_pkg::GROUP_TOKENS;
                     out_count = '0;
                     phase     = (size_decl == 24'd0) ? lzwd_pkg::PH_DONE
                                                      : lzwd_pkg::PH_TOKEN;
                  end
               end
            end
            lzwd_pkg::PH_TOKEN: begin
               if (tok_pos >= lzwd_pkg::GROUP_TOKENS) begin
                  flag_bits = b;
                  tok_pos   = 4'd0;
               end else if (flag_bits[3'd7 - tok_pos[2:0]]) begin
                  ref_hi = b;
                  phase  = lzwd_pkg::PH_REF2;
               end else begin
                  tok_pos = tok_pos + 4'd1;
                  fin = emit_out(b);
               end
            end
            default: begin
               span  = {1'b0, ref_hi[3:0], b} + 13'd1;
               len   = {1'b0, ref_hi[7:4]} + lzwd_pkg::LEN_BIAS;
               owed  = size_decl - out_count;
               phase = lzwd_pkg::PH_TOKEN;
               tok_pos = tok_pos + 4'd1;
               if (24'(span) > out_count) begin
                  owe_beat('{data: 8'h00, last: 1'b0,
                             status: lzwd_pkg::ST_BAD_REF, eod: 1'b0});
                  halted = 1'b1;
               end else begin
                  // clip to what is still owed, copy byte by byte so overlaps repeat
                  if (24'(len) > owed)
                     len = owed[4:0];
                  for (i = 0; i < int'(len) && !fin; i++) begin
                     src = wr_ptr - span[11:0];
                     fin = emit_out(hist_win[src]);
                  end
               end
            end
         endcase
      end
      if (decoded_q.size() > base) begin
         tail = decoded_q.pop_back();
         tail.last = 1'b1;
         owe_beat(tail);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // presents one compressed byte and holds it until the beat is taken
   task automatic send_byte(input logic [7:0] b, input logic start);
      logic took;
      if (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_stream_start <= start;
      // ready is looked at mid-cycle, where nothing is changing
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      decode_byte(b, start);
      bytes_sent++;
      if (start)
         streams_opened++;
   endtask

   // holds off the sender until every owed beat is out, then lets the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_header(input logic [23:0] size, input logic start);
      send_byte(lzwd_pkg::HDR_TYPE, start);
      send_byte(size[7:0], 1'b0);
      send_byte(size[15:8], 1'b0);
      send_byte(size[23:16], 1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 14);
      end
   end

   // each beat is taken mid-cycle, before the edge that completes it
   always @(negedge clock) begin
      out_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $error("rsp beat with nothing owed: out_byte %0h status %0d",
                   rsp_out_byte, rsp_status);
            errors++;
         end else begin
            want = decoded_q.pop_front();
            if (want.status == lzwd_pkg::ST_DATA)
               data_beats++;
            else
               fault_beats++;
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_end_of_data !== want.eod) begin
               $error("end_of_data: expected %0d, got %0d", want.eod, rsp_end_of_data);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("lz77_window_decompressor: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // straight after reset a header is expected even without stream_start
   task automatic test_stream_without_start();
      send_header(24'd3, 1'b0);
      send_byte(8'h00, 1'b0);          // all-literal group
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);          // completes the size
      send_byte(8'h81, 1'b0);          // ignored once done
      wait_idle();
   endtask

   task automatic test_zero_size();
      send_header(24'd0, 1'b1);
      send_byte(8'h42, 1'b0);          // done at once, so ignored
      wait_idle();
   endtask

   task automatic test_bad_type();
      send_byte(8'hEF, 1'b1);
      send_byte(lzwd_pkg::HDR_TYPE, 1'b0);   // halted, ignored
      wait_idle();
   endtask

   // widest possible distance with nothing produced yet
   task automatic test_bad_reference();
      send_header(24'd10, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      wait_idle();
   endtask

   // longest run at distance one, clipped to the five bytes still owed
   task automatic test_copy_overlap_clip();
      send_header(24'd6, 1'b1);
      send_byte(8'h40, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h00, 1'b0);
      wait_idle();
   endtask

   // one well-formed stream with random content, or a spoilt one
   task automatic random_stream(input int size, input bit long_refs, input fault_type fault);
      int          made;
      int          goal;
      int          lim;
      int          span;
      int          len;
      int          k;
      bit          broke;
      logic [7:0]  flags;
      logic [7:0]  bad;
      logic [11:0] code;
      logic [23:0] decl;
      if (fault == FAULT_TYPE) begin
         bad = 8'($urandom);
         if (bad == lzwd_pkg::HDR_TYPE)
            bad = ~bad;
         send_byte(bad, 1'b1);
         send_byte(8'($urandom), 1'b0);
      end else begin
         // a cut stream declares a big size and stops early
         decl = (fault == FAULT_CUT) ? 24'($urandom_range(64, 24'hFFFFFF)) : 24'(size);
         goal = (fault == FAULT_CUT) ? $urandom_range(0, 30) : size;
         send_header(decl, 1'b1);
         made  = 0;
         broke = 1'b0;
         while (made < goal && !broke) begin
            flags = 8'($urandom);
            if (made == 0 && fault != FAULT_REF)
               flags[7] = 1'b0;
            if (long_refs)
               flags = (made == 0) ? 8'h7F : 8'hFF;
            send_byte(flags, 1'b0);
            for (k = 7; k >= 0 && made < goal && !broke; k--) begin
               if (flags[k]) begin
                  len = long_refs ? 15 : $urandom_range(0, 15);
                  if (fault == FAULT_REF && made < WIN) begin
                     span  = $urandom_range(made + 1, WIN);
                     broke = 1'b1;
                  end else begin
                     lim = (made < WIN) ? made : WIN;
                     case ($urandom_range(0, 3))
                        0:       span = 1;
                        1:       span = lim;
                        default: span = $urandom_range(1, lim);
                     endcase
                     if (span > widest_span)
                        widest_span = span;
                  end
                  code = 12'(span - 1);
                  send_byte({4'(len), code[11:8]}, 1'b0);
                  send_byte(code[7:0], 1'b0);
                  made += len + 3;
               end else begin
                  send_byte(8'($urandom), 1'b0);
                  made++;
               end
            end
         end
         if (made > longest_stream)
            longest_stream = made;
         // a stray byte past the end of the stream
         if (!long_refs && $urandom_range(0, 3) == 0)
            send_byte(8'($urandom), 1'b0);
      end
   endtask

   task automatic test_random_streams();
      int        target;
      int        pick;
      int        size;
      fault_type fault;
      target = bytes_sent + 110;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 19);
         case (pick)
            0, 1:    fault = FAULT_TYPE;
            2, 3:    fault = FAULT_REF;
            4:       fault = FAULT_CUT;
            default: fault = FAULT_NONE;
         endcase
         size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 60);
         random_stream(size, 1'b0, fault);
         // random noise without stream_start
         if ($urandom_range(0, 19) == 0)
            send_byte(8'($urandom), 1'b0);
         if ($urandom_range(0, 5) == 0)
            wait_idle();
      end
      wait_idle();
   endtask

   // back-to-back longest copies with no idling on either side
   task automatic test_long_runs();
      calm = 1'b1;
      random_stream(180, 1'b1, FAULT_NONE);
      wait_idle();
      calm = 1'b0;
   endtask

   initial begin
      restart_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stream_without_start();
      test_zero_size();
      test_bad_type();
      test_bad_reference();
      test_copy_overlap_clip();
      test_random_streams();
      test_long_runs();

      wait_idle();
      $display("covered %0d streams from %0d compressed beats: %0d data beats, %0d error beats",
               streams_opened, bytes_sent, data_beats, fault_beats);
      $display("widest back-reference distance %0d, longest stream %0d bytes",
               widest_span, longest_stream);
      if (errors == 0 && decoded_q.size() == 0) begin
         $display("lz77_window_decompressor: match");
      end else begin
         $display("lz77_window_decompressor: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lzwd_pkg.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_datapath.sv
rtl/lz77_window_decompressor.sv
dv/tb_top.sv
